// ===== design/pjs_pkg.sv =====
// ----------------------------------------------------------------------------
// pjs_pkg
// Shared types, widths and codes for the priority job scheduler.
// ----------------------------------------------------------------------------
package pjs_pkg;

   localparam int MAX_JOBS = 16;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int TIME_W   = 16;
   localparam int BURST_W  = 16;
   localparam int PRIO_W   = 8;
   localparam int CSR_W    = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [CNT_W-1:0]  JOBS_CNT = CNT_W'(MAX_JOBS);

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADMIT,
      ST_PICK,
      ST_SCAN,
      ST_REMOVE,
      ST_EXEC,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] total;
      logic [BURST_W-1:0] left;
      logic [PRIO_W-1:0]  prio;
      logic               queued;
   } job_cell_type;

   typedef struct packed {
      logic load;
      logic dec;
      logic set_queued;
      logic clr_queued;
   } job_ctl_type;

   typedef struct packed {
      logic               load_error;
      logic               cpu_idle;
      logic [IDX_W-1:0]   running_job;
      logic               job_done;
      logic [TIME_W-1:0]  finish_time;
      logic [TIME_W-1:0]  turnaround;
      logic [TIME_W-1:0]  wait_time;
      logic               all_done;
   } rsp_type;

endpackage

// ===== design/pjs_req_if.sv =====
// ----------------------------------------------------------------------------
// pjs_req_if
// Request channel: load and tick items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pjs_req_if import pjs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [IDX_W-1:0]    job_index;
   logic [TIME_W-1:0]   arrival_time;
   logic [BURST_W-1:0]  burst_length;
   logic [PRIO_W-1:0]   priority_req;

   modport source (output valid, kind, job_index, arrival_time, burst_length,
                   priority_req, input ready);
   modport sink   (input valid, kind, job_index, arrival_time, burst_length,
                   priority_req, output ready);
endinterface

// ===== design/pjs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pjs_rsp_if
// Response channel: one result per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pjs_rsp_if import pjs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                load_error;
   logic                cpu_idle;
   logic [IDX_W-1:0]    running_job;
   logic                job_done;
   logic [TIME_W-1:0]   finish_time;
   logic [TIME_W-1:0]   turnaround;
   logic [TIME_W-1:0]   wait_time;
   logic                all_done;

   modport source (output valid, load_error, cpu_idle, running_job, job_done,
                   finish_time, turnaround, wait_time, all_done, input ready);
   modport sink   (input valid, load_error, cpu_idle, running_job, job_done,
                   finish_time, turnaround, wait_time, all_done, output ready);
endinterface

// ===== design/pjs_job_cell.sv =====
// ----------------------------------------------------------------------------
// pjs_job_cell
// One job slot: arrival, burst, remaining service, priority, queued mark.
// ----------------------------------------------------------------------------
module pjs_job_cell import pjs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  job_ctl_type        ctl,
   input  logic [TIME_W-1:0]  wr_arrival,
   input  logic [BURST_W-1:0] wr_burst,
   input  logic [PRIO_W-1:0]  wr_prio,
   output job_cell_type       entry
);
   logic [BURST_W-1:0] left_ff, left_in;
   logic               queued_ff, queued_in;
   logic [TIME_W-1:0]  arrival_ff;
   logic [BURST_W-1:0] total_ff;
   logic [PRIO_W-1:0]  prio_ff;

   always_comb begin
      left_in = left_ff;
      if (ctl.load) begin
         left_in = wr_burst;
      end else if (ctl.dec && left_ff != '0) begin
         left_in = left_ff - BURST_W'(1);
      end
      queued_in = queued_ff;
      if (ctl.set_queued) begin
         queued_in = 1'b1;
      end else if (ctl.clr_queued) begin
         queued_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         queued_ff <= 1'b0;
      end else begin
         left_ff   <= left_in;
         queued_ff <= queued_in;
      end
   end

   // table fields: undefined until first load
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         arrival_ff <= wr_arrival;
         total_ff   <= wr_burst;
         prio_ff    <= wr_prio;
      end
   end

   assign entry = '{arrival: arrival_ff, total: total_ff, left: left_ff,
                    prio: prio_ff, queued: queued_ff};
endmodule

// ===== design/pjs_queue_cell.sv =====
// ----------------------------------------------------------------------------
// pjs_queue_cell
// One ready-queue entry: takes an appended job or its right neighbor.
// ----------------------------------------------------------------------------
module pjs_queue_cell import pjs_pkg::*; (
   input  logic             clock,
   input  logic             append,
   input  logic [IDX_W-1:0] append_job,
   input  logic             shift,
   input  logic [IDX_W-1:0] neighbor_job,
   output logic [IDX_W-1:0] job
);
   logic [IDX_W-1:0] job_ff, job_in;

   always_comb begin
      job_in = job_ff;
      if (append) begin
         job_in = append_job;
      end else if (shift) begin
         job_in = neighbor_job;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job = job_ff;
endmodule

// ===== design/priority_job_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// priority_job_scheduler_top
// Non-preemptive priority scheduler built from a row of job cells and a
// row of ready-queue cells, sequenced one item at a time.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req_ch  | in  | valid/ready        | kind, job_index, arrival_time,
//          |     |                    | burst_length, priority_req
//  rsp_ch  | out | valid/ready        | load_error .. all_done
//  csr_*   | in  | csr_we (no stall)  | csr_wdata = job_count
//
//  A load goes from idle straight to finish. A tick first walks the job
//  row for arrivals (job_count caps at 16), then picks: when the CPU is
//  busy or the queue is empty it goes to execute, else it scans the queue
//  for the highest priority, removes that job and executes; then finish.
//  Finish holds while the output register is full.
//  The next item is taken while a result waits in the output register.
//  Synchronous reset clears burst counts, queue, time and control; job
//  table payload stays undefined until loaded. No clearing pass.
// ----------------------------------------------------------------------------
module priority_job_scheduler_top import pjs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pjs_req_if.sink          req_ch,
   pjs_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);
   state_type state_ff, state_in;

   logic [CSR_W-1:0]  job_cnt_ff;
   logic [CNT_W-1:0]  active_cnt;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  best_ff, best_in;
   logic [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [CNT_W-1:0]  qcount_ff, qcount_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic              busy_ff, busy_in;
   logic              tick_ff, tick_in;
   rsp_type           res_ff, res_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   job_cell_type      cells [MAX_JOBS];
   job_ctl_type       ctl   [MAX_JOBS];
   logic [IDX_W-1:0]  qjob  [MAX_JOBS];

   logic              accept, slot_free, load_ok, join_ok, all_done;
   logic [IDX_W-1:0]  q_addr, q_rd, rd_addr;
   job_cell_type      rd_cell;
   logic [TIME_W-1:0] time_next, tat;
   logic              finishing;

   // control strobes
   logic              do_load, do_join, do_scan_upd, do_remove, do_exec;

   assign active_cnt = (job_cnt_ff > JOBS_CNT) ? JOBS_CNT : CNT_W'(job_cnt_ff);
   assign accept     = req_ch.valid && req_ch.ready;
   assign slot_free  = !out_valid_ff || rsp_ch.ready;

   // single shared read port into each row
   assign q_addr  = (state_ff == ST_REMOVE) ? best_ff : k_ff[IDX_W-1:0];
   assign q_rd    = qjob[q_addr];
   assign rd_addr = (state_ff == ST_ADMIT) ? idx_ff[IDX_W-1:0] :
                    (state_ff == ST_SCAN)  ? q_rd : cur_ff;
   assign rd_cell = cells[rd_addr];

   assign load_ok = (CNT_W'(req_ch.job_index) < active_cnt) &&
                    (req_ch.burst_length != '0);
   assign join_ok = (rd_cell.left != '0) && (rd_cell.arrival == time_ff) &&
                    !(busy_ff && cur_ff == idx_ff[IDX_W-1:0]) && !rd_cell.queued;

   assign time_next = (time_ff == TIME_MAX) ? time_ff : time_ff + TIME_W'(1);
   assign finishing = rd_cell.left <= BURST_W'(1);
   assign tat       = time_next - rd_cell.arrival;

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < MAX_JOBS; i++) begin
         if (CNT_W'(i) < active_cnt && cells[i].left != '0) begin
            all_done = 1'b0;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.kind == KIND_TICK) ? ST_ADMIT : ST_FIN;
            end
         end
         ST_ADMIT: begin
            if (idx_ff >= active_cnt) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = (busy_ff || qcount_ff == '0) ? ST_EXEC : ST_SCAN;
         end
         ST_SCAN: begin
            if (k_ff >= qcount_ff) begin
               state_in = ST_REMOVE;
            end
         end
         ST_REMOVE: state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_FIN;
         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ch.ready = 1'b0;
      do_load      = 1'b0;
      do_join      = 1'b0;
      do_scan_upd  = 1'b0;
      do_remove    = 1'b0;
      do_exec      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            do_load      = accept && req_ch.kind == KIND_LOAD && load_ok;
         end
         ST_ADMIT:  do_join     = idx_ff < active_cnt && join_ok;
         ST_SCAN:   do_scan_upd = k_ff < qcount_ff &&
                                  (k_ff == '0 || rd_cell.prio > best_prio_ff);
         ST_REMOVE: do_remove   = 1'b1;
         ST_EXEC:   do_exec     = 1'b1;
         default: ;
      endcase
   end

   // per-cell control
   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         ctl[i].load       = do_load && req_ch.job_index == IDX_W'(i);
         ctl[i].dec        = do_exec && busy_ff && cur_ff == IDX_W'(i);
         ctl[i].set_queued = do_join && idx_ff[IDX_W-1:0] == IDX_W'(i);
         ctl[i].clr_queued = do_remove && q_rd == IDX_W'(i);
      end
   end

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_row
      pjs_job_cell u_job (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[g]),
         .wr_arrival (req_ch.arrival_time),
         .wr_burst   (req_ch.burst_length),
         .wr_prio    (req_ch.priority_req),
         .entry      (cells[g])
      );
      pjs_queue_cell u_q (
         .clock        (clock),
         .append       (do_join && qcount_ff == CNT_W'(g)),
         .append_job   (idx_ff[IDX_W-1:0]),
         .shift        (do_remove && IDX_W'(g) >= best_ff),
         .neighbor_job (qjob[(g < MAX_JOBS - 1) ? g + 1 : g]),
         .job          (qjob[g])
      );
   end

   // datapath next values
   always_comb begin
      idx_in       = idx_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      best_prio_in = best_prio_ff;
      qcount_in    = qcount_ff;
      time_in      = time_ff;
      cur_in       = cur_ff;
      busy_in      = busy_ff;
      tick_in      = tick_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         // start a fresh item
         idx_in     = '0;
         k_in       = '0;
         tick_in    = req_ch.kind == KIND_TICK;
         res_in     = '0;
         res_in.load_error = req_ch.kind == KIND_LOAD && !load_ok;
      end
      if (state_ff == ST_ADMIT) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (do_join) begin
         qcount_in = qcount_ff + CNT_W'(1);
      end
      if (state_ff == ST_SCAN) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (do_scan_upd) begin
         best_in      = k_ff[IDX_W-1:0];
         best_prio_in = rd_cell.prio;
      end
      if (do_remove) begin
         cur_in    = q_rd;
         busy_in   = 1'b1;
         qcount_in = qcount_ff - CNT_W'(1);
      end
      if (do_exec) begin
         time_in = time_next;
         if (busy_ff) begin
            res_in.running_job = cur_ff;
            if (finishing) begin
               busy_in            = 1'b0;
               res_in.job_done    = 1'b1;
               res_in.finish_time = time_next;
               res_in.turnaround  = tat;
               res_in.wait_time   = (tat >= rd_cell.total) ? tat - rd_cell.total : '0;
            end
         end else begin
            res_in.cpu_idle = 1'b1;
         end
      end
      if (state_ff == ST_FIN && slot_free) begin
         // hand result to output register; all_done sees the updated row
         out_in          = res_ff;
         out_in.all_done = tick_ff && all_done;
         out_valid_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_cnt_ff   <= CSR_W'(1);
         qcount_ff    <= '0;
         time_ff      <= '0;
         cur_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_cnt_ff   <= csr_we ? csr_wdata : job_cnt_ff;
         qcount_ff    <= qcount_in;
         time_ff      <= time_in;
         cur_ff       <= cur_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      best_ff      <= best_in;
      best_prio_ff <= best_prio_in;
      tick_ff      <= tick_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.load_error  = out_ff.load_error;
   assign rsp_ch.cpu_idle    = out_ff.cpu_idle;
   assign rsp_ch.running_job = out_ff.running_job;
   assign rsp_ch.job_done    = out_ff.job_done;
   assign rsp_ch.finish_time = out_ff.finish_time;
   assign rsp_ch.turnaround  = out_ff.turnaround;
   assign rsp_ch.wait_time   = out_ff.wait_time;
   assign rsp_ch.all_done    = out_ff.all_done;
endmodule

// ===== design/pjs_checker.sv =====
// ----------------------------------------------------------------------------
// pjs_checker
// Port-level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pjs_checker import pjs_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              load_error,
   input logic              cpu_idle,
   input logic [IDX_W-1:0]  running_job,
   input logic              job_done,
   input logic [TIME_W-1:0] turnaround,
   input logic [TIME_W-1:0] wait_time,
   input logic              all_done
);
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transfer");

   a_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(running_job) && $stable(turnaround))
      else $error("rsp payload changed while stalled");

   a_load_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && load_error |-> !cpu_idle && !job_done && !all_done)
      else $error("load result carries tick fields");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cpu_idle |-> !job_done && running_job == '0)
      else $error("idle tick reports a job");

   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && job_done |-> wait_time <= turnaround)
      else $error("wait exceeds turnaround");
endmodule

bind priority_job_scheduler_top pjs_checker u_pjs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .load_error  (rsp_ch.load_error),
   .cpu_idle    (rsp_ch.cpu_idle),
   .running_job (rsp_ch.running_job),
   .job_done    (rsp_ch.job_done),
   .turnaround  (rsp_ch.turnaround),
   .wait_time   (rsp_ch.wait_time),
   .all_done    (rsp_ch.all_done)
);
